// File: hdl/plpe_pkg.sv
// ----------------------------------------------------------------------------
// plpe_pkg: shared definitions for the piecewise linear evaluator
// Status and command codes, register indexes and the divider stage record.
// ----------------------------------------------------------------------------
package plpe_pkg;

  // Default table depth of the top level.
  localparam int MAX_SEG_DEF = 64;

  // Field widths fixed by the interface.
  localparam int DATA_W    = 32;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 1;

  // One divider cell per quotient bit.
  localparam int DIV_STEPS = PROD_W;

  // Input command codes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_TABLE = 2'd1;
  localparam logic [1:0] ST_MISS      = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Record handed from one divider cell to the next.
  typedef struct packed {
    logic              vld;
    logic              neg;
    logic [DATA_W-1:0] rem;
    logic [PROD_W-1:0] num;
    logic [DATA_W-1:0] den;
  } plpe_div_t;

endpackage

// File: hdl/plpe_div_cell.sv
// ----------------------------------------------------------------------------
// plpe_div_cell: one restoring division step
// Shifts one dividend bit into the remainder, subtracts the divisor when it
// fits and registers the updated record for the next cell.
// ----------------------------------------------------------------------------
module plpe_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  plpe_pkg::plpe_div_t d_in,
  output plpe_pkg::plpe_div_t d_out
);
  import plpe_pkg::*;

  logic [DATA_W:0]   sh;
  logic [DATA_W:0]   diff;
  plpe_div_t         step;
  logic              vld_r;
  plpe_div_t         pay_r;

  always_comb begin
    sh       = {d_in.rem, d_in.num[PROD_W-1]};
    diff     = sh - {1'b0, d_in.den};
    step     = d_in;
    step.num = {d_in.num[PROD_W-2:0], 1'b0};
    if (sh >= {1'b0, d_in.den}) begin
      step.rem    = diff[DATA_W-1:0];
      step.num[0] = 1'b1;
    end else begin
      step.rem = sh[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= d_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= step;
  end

  always_comb begin
    d_out     = pay_r;
    d_out.vld = vld_r;
  end

endmodule

// File: hdl/plpe_divider.sv
// ----------------------------------------------------------------------------
// plpe_divider: row of division cells
// Unsigned 64 by 32 bit division, one quotient bit per cell, each cell
// registering its record for the next one.
// ----------------------------------------------------------------------------
module plpe_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  plpe_pkg::plpe_div_t div_in,
  output plpe_pkg::plpe_div_t div_out
);
  import plpe_pkg::*;

  plpe_div_t link [DIV_STEPS+1];

  assign link[0] = div_in;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
    plpe_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (link[g]),
      .d_out (link[g+1])
    );
  end

  assign div_out = link[DIV_STEPS];

endmodule

// File: hdl/piecewise_linear_evaluator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_evaluator: segment table lookup and linear evaluation
// Holds a table of segments and evaluates y = (slope*x + intercept) / scale.
// ----------------------------------------------------------------------------
// Usage. The input channel carries one transaction per command. A write
// transaction (mode 0) stores one segment at entry_index and produces no
// result; indexes at or above MAX_SEGMENTS are dropped. An evaluate
// transaction (mode 1) produces exactly one result transaction with y_value
// and status (0 ok, 1 invalid table, 2 no covering segment, 3 overflow).
// A write leaves the block idle. An evaluate runs alone: the table check
// streams the N entries in use through the memory read port, the binary
// search reads and then compares the midpoint for each probe, and the
// multiply, the add and the row of 64 divider cells follow until the
// result sits in the output register. The input side is ready again once
// that result is registered, even while the receiver still stalls the
// output; a second result waits until the first one is taken. The
// configuration registers (the segment count and the coefficient scale)
// are written through cfg_wr_en/cfg_index/cfg_data; they are to be written
// only while the block is idle, which the block itself does not enforce.
// Reset returns to idle, drops any pending result, clears the segment count
// to 0 and sets the scale to 1. Table contents are not cleared; an entry
// must be written before an evaluate reads it.
// ----------------------------------------------------------------------------
module piecewise_linear_evaluator #(
  parameter int MAX_SEGMENTS = plpe_pkg::MAX_SEG_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Command channel.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [plpe_pkg::IDX_W-1:0]    in_entry_index,
  input  logic signed [plpe_pkg::DATA_W-1:0] in_seg_x_min,
  input  logic signed [plpe_pkg::DATA_W-1:0] in_seg_x_max,
  input  logic signed [plpe_pkg::DATA_W-1:0] in_seg_slope,
  input  logic signed [plpe_pkg::DATA_W-1:0] in_seg_intercept,
  input  logic signed [plpe_pkg::DATA_W-1:0] in_x_value,
  // Result channel.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [plpe_pkg::DATA_W-1:0] out_y_value,
  output logic [1:0]                    out_status,
  // Configuration write port.
  input  logic                          cfg_wr_en,
  input  logic [plpe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [plpe_pkg::DATA_W-1:0]   cfg_data
);
  import plpe_pkg::*;

  // Memory address width and width of counters that reach MAX_SEGMENTS.
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int WORD_W = 4 * DATA_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SCMP  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_DIVGO = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // Segment memory: {x_min, x_max, slope, intercept} per entry.
  logic [WORD_W-1:0] mem [MAX_SEGMENTS];
  logic [WORD_W-1:0] rd_q_r;
  logic [AW-1:0]     rd_addr;
  logic [AW+IDX_W-1:0] wr_ext;
  logic              wr_en;

  logic signed [DATA_W-1:0] rd_lo;
  logic signed [DATA_W-1:0] rd_hi;

  // Control state.
  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  segcnt_r;
  logic [DATA_W-1:0] scale_r;
  logic              rcv_v_r, rcv_v_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath state.
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic              rcv_first_r, rcv_first_nxt;
  logic              rcv_last_r, rcv_last_nxt;
  logic signed [DATA_W-1:0] prev_lo_r, prev_lo_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     mid;
  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] slope_r, slope_nxt;
  logic signed [DATA_W-1:0] icpt_r, icpt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] sum_r, sum_nxt;
  logic [DATA_W-1:0] res_y_r, res_y_nxt;
  logic [1:0]        res_st_r, res_st_nxt;
  logic [DATA_W-1:0] out_y_r, out_y_nxt;
  logic [1:0]        out_st_r, out_st_nxt;

  logic [CW+CNT_W-1:0] count_ext;
  logic              table_bad;
  logic              in_acc;
  logic              q_fits;
  logic [PROD_W-1:0] quo;

  plpe_div_t div_in;
  plpe_div_t div_out;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // Write side of the segment memory.
  assign wr_ext = {{AW{1'b0}}, in_entry_index};
  assign wr_en  = in_acc && (in_mode == MODE_WRITE) &&
                  (wr_ext < (AW+IDX_W)'(MAX_SEGMENTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ext[AW-1:0]] <= {in_seg_x_min, in_seg_x_max, in_seg_slope, in_seg_intercept};
    end
    rd_q_r <= mem[rd_addr];
  end

  assign rd_lo = rd_q_r[4*DATA_W-1:3*DATA_W];
  assign rd_hi = rd_q_r[3*DATA_W-1:2*DATA_W];

  // The check streams entries in index order; the search reads the midpoint.
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign rd_addr = (state_r == S_CHECK) ? iss_r[AW-1:0] : mid[AW-1:0];

  // Count and scale checks that need no table read.
  assign count_ext = {{CW{1'b0}}, segcnt_r};
  assign table_bad = (segcnt_r == '0) || (scale_r == '0) ||
                     (count_ext > (CW+CNT_W)'(MAX_SEGMENTS));

  // Divider feed: magnitude of the 64-bit sum and its sign.
  always_comb begin
    div_in     = '0;
    div_in.vld = (state_r == S_DIVGO);
    div_in.neg = sum_r[PROD_W-1];
    div_in.num = sum_r[PROD_W-1] ? (~sum_r + PROD_W'(1)) : sum_r;
    div_in.den = scale_r;
  end

  plpe_divider u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_in  (div_in),
    .div_out (div_out)
  );

  // A negative quotient may reach 2^31 in magnitude, a positive one 2^31-1.
  assign quo    = div_out.num;
  assign q_fits = div_out.neg ?
                  ((quo[PROD_W-1:DATA_W] == '0) &&
                   (!quo[DATA_W-1] || (quo[DATA_W-2:0] == '0))) :
                  (quo[PROD_W-1:DATA_W-1] == '0);

  always_comb begin
    state_nxt     = state_r;
    rcv_v_nxt     = 1'b0;
    cnt_nxt       = cnt_r;
    iss_nxt       = iss_r;
    rcv_first_nxt = rcv_first_r;
    rcv_last_nxt  = rcv_last_r;
    prev_lo_nxt   = prev_lo_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    x_nxt         = x_r;
    slope_nxt     = slope_r;
    icpt_nxt      = icpt_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    res_y_nxt     = res_y_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_y_nxt     = out_y_r;
    out_st_nxt    = out_st_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == MODE_EVAL)) begin
          x_nxt   = in_x_value;
          cnt_nxt = count_ext[CW-1:0];
          iss_nxt = '0;
          if (table_bad) begin
            res_y_nxt  = '0;
            res_st_nxt = ST_BAD_TABLE;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // Issue side: one read per cycle until every entry in use is out.
        if (iss_r != cnt_r) begin
          iss_nxt       = iss_r + CW'(1);
          rcv_v_nxt     = 1'b1;
          rcv_first_nxt = (iss_r == '0);
          rcv_last_nxt  = (iss_r == (cnt_r - CW'(1)));
        end
        // Return side: check the entry read in the previous cycle.
        if (rcv_v_r) begin
          prev_lo_nxt = rd_lo;
          if ((rd_lo > rd_hi) || (!rcv_first_r && (rd_lo <= prev_lo_r))) begin
            res_y_nxt  = '0;
            res_st_nxt = ST_BAD_TABLE;
            state_nxt  = S_DONE;
          end else if (rcv_last_r) begin
            lo_nxt    = '0;
            hi_nxt    = cnt_r;
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          state_nxt = S_SCMP;
        end else begin
          res_y_nxt  = '0;
          res_st_nxt = ST_MISS;
          state_nxt  = S_DONE;
        end
      end
      S_SCMP: begin
        if (x_r < rd_lo) begin
          hi_nxt    = mid_r;
          state_nxt = S_SRD;
        end else if (x_r > rd_hi) begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = S_SRD;
        end else begin
          slope_nxt = rd_q_r[2*DATA_W-1:DATA_W];
          icpt_nxt  = rd_q_r[DATA_W-1:0];
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = slope_r * x_r;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        sum_nxt   = prod_r + {{DATA_W{icpt_r[DATA_W-1]}}, icpt_r};
        state_nxt = S_DIVGO;
      end
      S_DIVGO: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_out.vld) begin
          if (q_fits) begin
            res_y_nxt  = div_out.neg ? (~quo[DATA_W-1:0] + DATA_W'(1)) : quo[DATA_W-1:0];
            res_st_nxt = ST_OK;
          end else begin
            res_y_nxt  = '0;
            res_st_nxt = ST_OVERFLOW;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_y_nxt     = res_y_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rcv_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
      segcnt_r    <= '0;
      scale_r     <= DATA_W'(1);
    end else begin
      state_r     <= state_nxt;
      rcv_v_r     <= rcv_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SEG_COUNT: segcnt_r <= cfg_data[CNT_W-1:0];
          CFG_SCALE:     scale_r  <= cfg_data;
          default:       segcnt_r <= segcnt_r;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    iss_r       <= iss_nxt;
    rcv_first_r <= rcv_first_nxt;
    rcv_last_r  <= rcv_last_nxt;
    prev_lo_r   <= prev_lo_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    x_r         <= x_nxt;
    slope_r     <= slope_nxt;
    icpt_r      <= icpt_nxt;
    prod_r      <= prod_nxt;
    sum_r       <= sum_nxt;
    res_y_r     <= res_y_nxt;
    res_st_r    <= res_st_nxt;
    out_y_r     <= out_y_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_y_value = out_y_r;
  assign out_status  = out_st_r;

endmodule

// File: hdl/plpe_checker.sv
// ----------------------------------------------------------------------------
// plpe_checker: port level checks for the piecewise linear evaluator
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
module plpe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_mode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [plpe_pkg::DATA_W-1:0] out_y_value,
  input logic [1:0]                  out_status
);
  import plpe_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_y_value) && $stable(out_status))
    else $error("result changed while stalled");

  // Any error status carries a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_y_value == '0))
    else $error("nonzero y_value with error status");

  // A segment write leaves the block ready for the next command.
  a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_WRITE) |=> in_ready)
    else $error("not ready after a segment write");

  // The input is not ready right after an evaluate is accepted.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_EVAL) |=> !in_ready)
    else $error("ready right after an evaluate");

endmodule

bind piecewise_linear_evaluator plpe_checker u_plpe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_mode     (in_mode),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_y_value (out_y_value),
  .out_status  (out_status)
);
